>>> hdl/wcms_pkg.sv
// Shared constants, types and command/status structs for the cut search core.
package wcms_pkg;

    localparam int MAX_V      = 24;
    localparam int W_BITS     = 16;
    localparam int IDX_W      = 5;
    localparam int ROW_W      = MAX_V;
    localparam int WIN_W      = 16;
    localparam int SPLIT_W    = MAX_V - 1;
    localparam int D_W        = W_BITS + IDX_W + 1;
    localparam int PROD_W     = W_BITS + 1 + D_W;
    localparam int COST_W     = 2 * W_BITS + 9;
    localparam int ACC_W      = COST_W + 1;
    localparam int BEST_W     = COST_W + 1;
    localparam int OUT_COST_W = 40;
    localparam int HITS_W     = 24;

    localparam logic [BEST_W-1:0]     BEST_INIT = '1;
    localparam logic [OUT_COST_W-1:0] COST_SAT  = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADJ,
        ST_SUM,
        ST_SUM_END,
        ST_LOAD,
        ST_SEARCH,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic start;
        logic adj_step;
        logic sum_step;
        logic load;
        logic search_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic step_last;
        logic h_last;
        logic n_one;
    } t_stat;

endpackage

>>> hdl/weighted_cut_minimum_search_core.sv
// Top level of the weighted cut minimum search core.
// Vertices load one beat per cycle while the input is not stalled. The beat marked last
// (index n-1) starts a search, and the core stalls its input until the result is formed,
// also while an earlier result still waits in the output register. ST_ADJ builds
// per-vertex neighbor weight sums, ST_SUM and ST_SUM_END run the one multiplier for the
// starting cost, then come ST_LOAD, one Gray-code split per cycle in ST_SEARCH for the
// remaining 2^(n-1) - 1 splits, the drain states ST_DRAIN1 and ST_DRAIN2 and the emit
// state ST_FIN. Each flip costs one multiply by the balance of the flipped vertex. The
// result sits in an output register; loading of the next graph may go on while it waits.
module weighted_cut_minimum_search_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [wcms_pkg::IDX_W-1:0]          i_vertex_index,
    input  logic [wcms_pkg::ROW_W-1:0]          i_adjacency_row,
    input  logic [wcms_pkg::WIN_W-1:0]          i_vertex_weight,
    input  logic                                i_is_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [wcms_pkg::OUT_COST_W-1:0]     o_min_cost,
    output logic [wcms_pkg::HITS_W-1:0]         o_min_count,
    output logic [wcms_pkg::OUT_COST_W-1:0]     o_second_min_cost,
    output logic                                o_second_valid
);

    wcms_pkg::t_cmd  cmd;
    wcms_pkg::t_stat stat;
    logic            idx_ok;
    logic            wr_en;

    assign idx_ok = (i_vertex_index < wcms_pkg::IDX_W'(wcms_pkg::MAX_V));
    assign wr_en  = i_in_valid && !o_in_stall && idx_ok;

    wcms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_is_last),
        .i_in_idx_ok (idx_ok),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    wcms_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_wr_en           (wr_en),
        .i_wr_idx          (i_vertex_index),
        .i_wr_row          (i_adjacency_row),
        .i_wr_w            (i_vertex_weight),
        .o_min_cost        (o_min_cost),
        .o_min_count       (o_min_count),
        .o_second_min_cost (o_second_min_cost),
        .o_second_valid    (o_second_valid)
    );

endmodule

>>> hdl/wcms_ctrl.sv
// Sequencer for load, neighbor-sum setup, initial cost and split enumeration.
module wcms_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    input  logic            i_in_idx_ok,
    input  logic            i_out_stall,
    input  wcms_pkg::t_stat i_stat,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output wcms_pkg::t_cmd  o_cmd
);

    wcms_pkg::t_state r_state, n_state;
    logic             r_o_valid, n_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wcms_pkg::ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_o_valid  = r_o_valid && i_out_stall;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            wcms_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && i_in_last && i_in_idx_ok) begin
                    o_cmd.start = 1'b1;
                    n_state     = wcms_pkg::ST_ADJ;
                end
            end
            wcms_pkg::ST_ADJ: begin
                o_cmd.adj_step = 1'b1;
                if (i_stat.step_last) n_state = wcms_pkg::ST_SUM;
            end
            wcms_pkg::ST_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_stat.step_last) n_state = wcms_pkg::ST_SUM_END;
            end
            wcms_pkg::ST_SUM_END: n_state = wcms_pkg::ST_LOAD;
            wcms_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = i_stat.n_one ? wcms_pkg::ST_DRAIN1 : wcms_pkg::ST_SEARCH;
            end
            wcms_pkg::ST_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_stat.h_last) n_state = wcms_pkg::ST_DRAIN1;
            end
            wcms_pkg::ST_DRAIN1: n_state = wcms_pkg::ST_DRAIN2;
            wcms_pkg::ST_DRAIN2: n_state = wcms_pkg::ST_FIN;
            wcms_pkg::ST_FIN: begin
                if (!r_o_valid || !i_out_stall) begin
                    o_cmd.emit = 1'b1;
                    n_o_valid  = 1'b1;
                    n_state    = wcms_pkg::ST_IDLE;
                end
            end
            default: n_state = wcms_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid = r_o_valid;

endmodule

>>> hdl/wcms_dp.sv
// Datapath: vertex stores, neighbor balance registers, multiplier, cost and minimum tracking.
module wcms_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wcms_pkg::t_cmd                      i_cmd,
    output wcms_pkg::t_stat                     o_stat,
    input  logic                                i_wr_en,
    input  logic [wcms_pkg::IDX_W-1:0]          i_wr_idx,
    input  logic [wcms_pkg::ROW_W-1:0]          i_wr_row,
    input  logic [wcms_pkg::WIN_W-1:0]          i_wr_w,
    output logic [wcms_pkg::OUT_COST_W-1:0]     o_min_cost,
    output logic [wcms_pkg::HITS_W-1:0]         o_min_count,
    output logic [wcms_pkg::OUT_COST_W-1:0]     o_second_min_cost,
    output logic                                o_second_valid
);

    localparam int MV = wcms_pkg::MAX_V;

    logic [wcms_pkg::ROW_W-1:0]         r_row [MV];
    logic [wcms_pkg::W_BITS-1:0]        r_w   [MV];
    logic signed [wcms_pkg::D_W-1:0]    r_d   [MV];
    logic signed [wcms_pkg::D_W-1:0]    n_d   [MV];
    logic [MV-1:0]                      r_side, n_side;
    logic [wcms_pkg::IDX_W-1:0]         r_n, r_step;
    logic [wcms_pkg::SPLIT_W-1:0]       r_h, r_h_last;
    logic                               r_n_one;
    logic signed [wcms_pkg::PROD_W-1:0] r_prod, n_prod;
    logic                               r_sum_v, r_srch_v, r_cost_v;
    logic [wcms_pkg::ACC_W-1:0]         r_acc;
    logic [wcms_pkg::COST_W-1:0]        r_cost;
    logic [wcms_pkg::BEST_W-1:0]        r_best, r_runner, c_cost;
    logic [wcms_pkg::HITS_W-1:0]        r_hits;
    logic [wcms_pkg::IDX_W-1:0]         k, sel;
    logic [wcms_pkg::ROW_W-1:0]         row_v;
    logic [wcms_pkg::IDX_W-1:0]         v;
    logic signed [wcms_pkg::D_W-1:0]    w_v, w2_k;
    logic                               adj;
    logic                               second;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_row[i_wr_idx] <= i_wr_row;
            r_w[i_wr_idx]   <= i_wr_w[wcms_pkg::W_BITS-1:0];
        end
    end

    always_comb begin
        k = '0;
        for (int j = wcms_pkg::SPLIT_W - 1; j >= 0; j--) begin
            if (r_h[j]) k = wcms_pkg::IDX_W'(j + 1);
        end
    end

    assign v     = i_cmd.adj_step ? r_step : k;
    assign row_v = r_row[v];
    assign w_v   = wcms_pkg::D_W'(r_w[v]);
    assign w2_k  = wcms_pkg::D_W'({r_w[k], 1'b0});

    always_comb begin
        n_side = r_side;
        adj    = 1'b0;
        for (int x = 0; x < MV; x++) begin
            n_d[x] = r_d[x];
        end
        if (i_cmd.start) begin
            n_side = '0;
            for (int x = 0; x < MV; x++) begin
                n_d[x] = '0;
            end
        end else if (i_cmd.adj_step || i_cmd.search_step) begin
            for (int x = 0; x < MV; x++) begin
                if (wcms_pkg::IDX_W'(x) < v) begin
                    adj = r_row[x][v];
                end else if (wcms_pkg::IDX_W'(x) > v) begin
                    adj = row_v[x];
                end else begin
                    adj = 1'b0;
                end
                adj = adj && (wcms_pkg::IDX_W'(x) < r_n);
                if (i_cmd.adj_step) begin
                    if (adj) n_d[x] = r_d[x] + w_v;
                end else if (wcms_pkg::IDX_W'(x) == k) begin
                    n_d[x] = -r_d[x];
                end else if (adj) begin
                    n_d[x] = (r_side[x] == r_side[k]) ? r_d[x] - w2_k : r_d[x] + w2_k;
                end
            end
            if (i_cmd.search_step) n_side[k] = ~r_side[k];
        end
    end

    assign sel    = i_cmd.sum_step ? r_step : k;
    assign n_prod = $signed({1'b0, r_w[sel]}) * r_d[sel];

    always_ff @(posedge i_clk) begin
        for (int x = 0; x < MV; x++) begin
            r_d[x] <= n_d[x];
        end
        r_side <= n_side;
        r_prod <= n_prod;
        if (i_cmd.start) begin
            r_n      <= i_wr_idx + wcms_pkg::IDX_W'(1);
            r_n_one  <= (i_wr_idx == '0);
            r_h_last <= ~({wcms_pkg::SPLIT_W{1'b1}} << i_wr_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_h      <= '0;
            r_sum_v  <= 1'b0;
            r_srch_v <= 1'b0;
            r_cost_v <= 1'b0;
            r_acc    <= '0;
            r_best   <= wcms_pkg::BEST_INIT;
            r_runner <= wcms_pkg::BEST_INIT;
            r_hits   <= '0;
        end else begin
            r_sum_v  <= i_cmd.sum_step;
            r_srch_v <= i_cmd.search_step;
            if (i_cmd.start) begin
                r_step <= '0;
            end else if (i_cmd.adj_step || i_cmd.sum_step) begin
                r_step <= o_stat.step_last ? '0 : r_step + wcms_pkg::IDX_W'(1);
            end
            if (i_cmd.load) begin
                r_h <= wcms_pkg::SPLIT_W'(1);
            end else if (i_cmd.search_step) begin
                r_h <= r_h + wcms_pkg::SPLIT_W'(1);
            end
            if (i_cmd.start) begin
                r_acc <= '0;
            end else if (r_sum_v) begin
                r_acc <= r_acc + wcms_pkg::ACC_W'(unsigned'(r_prod));
            end
            if (i_cmd.load) begin
                r_cost   <= r_acc[wcms_pkg::ACC_W-1:1];
                r_cost_v <= 1'b1;
            end else if (r_srch_v) begin
                r_cost   <= r_cost - wcms_pkg::COST_W'(r_prod);
                r_cost_v <= 1'b1;
            end else begin
                r_cost_v <= 1'b0;
            end
            if (i_cmd.load) begin
                r_best   <= wcms_pkg::BEST_INIT;
                r_runner <= wcms_pkg::BEST_INIT;
                r_hits   <= '0;
            end else if (r_cost_v) begin
                if (c_cost < r_best) begin
                    r_runner <= r_best;
                    r_best   <= c_cost;
                    r_hits   <= wcms_pkg::HITS_W'(1);
                end else if (c_cost == r_best) begin
                    r_hits   <= r_hits + wcms_pkg::HITS_W'(1);
                end else if (c_cost < r_runner) begin
                    r_runner <= c_cost;
                end
            end
        end
    end

    assign c_cost = {1'b0, r_cost};
    assign second = (r_runner != wcms_pkg::BEST_INIT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_min_cost  <= (r_best > wcms_pkg::BEST_W'(wcms_pkg::COST_SAT))
                         ? wcms_pkg::COST_SAT : r_best[wcms_pkg::OUT_COST_W-1:0];
            o_min_count <= r_hits;
            if (!second) begin
                o_second_min_cost <= '0;
            end else if (r_runner > wcms_pkg::BEST_W'(wcms_pkg::COST_SAT)) begin
                o_second_min_cost <= wcms_pkg::COST_SAT;
            end else begin
                o_second_min_cost <= r_runner[wcms_pkg::OUT_COST_W-1:0];
            end
            o_second_valid <= second;
        end
    end

    assign o_stat.step_last = (r_step == r_n - wcms_pkg::IDX_W'(1));
    assign o_stat.h_last    = (r_h == r_h_last);
    assign o_stat.n_one     = r_n_one;

endmodule

>>> sim/testbench.sv
// Testbench for the weighted cut minimum search core: directed graphs, then random graphs.
`timescale 1ns / 1ps
module testbench;

    localparam int LIMIT = 3_000_000;

    typedef struct {
        logic [39:0] min_cost;
        logic [23:0] min_count;
        logic [39:0] second_cost;
        logic        second_ok;
    } t_cut_result;

    typedef struct {
        logic [4:0]  idx;
        logic [23:0] row;
        logic [15:0] wt;
        logic        last;
        logic        typed;
        t_cut_result res;
    } t_vertex_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [wcms_pkg::IDX_W-1:0] i_vertex_index = '0;
    logic [wcms_pkg::ROW_W-1:0] i_adjacency_row = '0;
    logic [wcms_pkg::WIN_W-1:0] i_vertex_weight = '0;
    logic i_is_last = 1'b0;
    logic i_out_stall = 1'b0;
    logic o_in_stall, o_out_valid, o_second_valid;
    logic [wcms_pkg::OUT_COST_W-1:0] o_min_cost, o_second_min_cost;
    logic [wcms_pkg::HITS_W-1:0] o_min_count;

    weighted_cut_minimum_search_core u_top (.*);

    logic [23:0] adj_copy[24];
    logic [15:0] wt_copy[24];
    bit written[24];
    t_cut_result pending_cuts[$];
    t_vertex_row directed_rows[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit done = 1'b0;

    initial forever #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_cut_result search_cuts(int n);
        t_cut_result r;
        logic [63:0] best, runner, cost;
        logic [23:0] side;
        int hits;
        best = '1;
        runner = '1;
        hits = 0;
        for (int s = 0; s < (1 << (n - 1)); s++) begin
            side = 24'(s << 1);
            cost = 0;
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                    if (adj_copy[i][j] && side[i] == side[j])
                        cost += 64'(wt_copy[i]) * 64'(wt_copy[j]);
            if (cost < best) begin
                runner = best;
                best = cost;
                hits = 1;
            end else if (cost == best) begin
                hits++;
            end else if (cost < runner) begin
                runner = cost;
            end
        end
        r.min_cost = (best > 64'hFF_FFFF_FFFF) ? '1 : best[39:0];
        r.min_count = hits[23:0];
        r.second_ok = (runner != '1);
        r.second_cost = !r.second_ok ? '0 : (runner > 64'hFF_FFFF_FFFF) ? '1 : runner[39:0];
        return r;
    endfunction

    task automatic send_vertex(t_vertex_row v);
        t_cut_result r;
        i_in_valid <= 1'b1;
        i_vertex_index <= v.idx;
        i_adjacency_row <= v.row;
        i_vertex_weight <= v.wt;
        i_is_last <= v.last;
        do @(posedge i_clk); while (o_in_stall);
        if (int'(v.idx) < wcms_pkg::MAX_V) begin
            adj_copy[v.idx] = v.row;
            wt_copy[v.idx] = v.wt;
            written[v.idx] = 1'b1;
            if (v.last) begin
                if (v.typed) r = v.res;
                else r = search_cuts(int'(v.idx) + 1);
                pending_cuts.insert(pending_cuts.size(), r);
            end
        end
        if (!quiet && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic dir_row(int idx, int row, int wt, bit last, bit typed = 0,
                           logic [39:0] mc = 0, int cnt = 0, logic [39:0] sc = 0,
                           bit sv = 0);
        t_vertex_row v;
        v.idx = 5'(idx);
        v.row = 24'(row);
        v.wt = 16'(wt);
        v.last = last;
        v.typed = typed;
        v.res = '{mc, 24'(cnt), sc, sv};
        directed_rows.insert(directed_rows.size(), v);
    endtask

    always @(posedge i_clk) begin
        t_cut_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cuts.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat, min_cost %0d", o_min_cost);
            end else begin
                e = pending_cuts.pop_front();
                if (o_min_cost !== e.min_cost || o_min_count !== e.min_count ||
                    o_second_min_cost !== e.second_cost || o_second_valid !== e.second_ok) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 e.min_cost, e.min_count, e.second_cost, e.second_ok,
                                 o_min_cost, o_min_count, o_second_min_cost,
                                 o_second_valid);
                end
            end
        end
        i_out_stall <= !quiet && ($urandom_range(99) < 25);
    end

    initial begin
        t_vertex_row v;
        int items, n, order[$], k;
        bit paused;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_row(0, 0, 0, 1, 1, 0, 1, 0, 0);
        dir_row(0, 24'hFFFFFF, 16'hFFFF, 0);
        dir_row(1, 24'hFFFFFF, 16'hFFFF, 1, 1, 0, 1, 40'd4294836225, 1);
        dir_row(24, 24'h000001, 16'h0001, 1);
        dir_row(31, 24'hFFFFFF, 16'hFFFF, 1);
        dir_row(1, 0, 1234, 1, 1, 0, 1, 40'd80870190, 1);
        dir_row(0, 0, 5, 0);
        dir_row(1, 0, 0, 1, 1, 0, 2, 0, 0);
        dir_row(0, 6, 1, 0);
        dir_row(1, 4, 1, 0);
        dir_row(2, 0, 1, 1, 1, 1, 3, 3, 1);
        for (int i = 0; i < 14; i++)
            dir_row(i, 24'hFFFFFF, (i % 3 == 2) ? 16'h5555 : 16'hFFFF, i == 13);
        dir_row(23, 24'hAAAAAA, 16'hAAAA, 0);
        foreach (directed_rows[i]) send_vertex(directed_rows[i]);

        items = 0;
        paused = 1'b0;
        while (items < 70) begin
            quiet = (items >= 40 && items < 60);
            if (!paused && items >= 55) begin
                paused = 1'b1;
                i_in_valid <= 1'b0;
                while (pending_cuts.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            k = $urandom_range(99);
            n = (k < 5) ? 1 : (k < 85) ? $urandom_range(2, 8) : $urandom_range(9, 12);
            order.delete();
            for (int i = 0; i < n - 1; i++)
                if (!written[i] || $urandom_range(99) < 80) order.insert(order.size(), i);
            order.shuffle();
            order.insert(order.size(), n - 1);
            foreach (order[i]) begin
                if ($urandom_range(99) < 8) begin
                    v.idx = 5'($urandom_range(24, 31));
                    v.row = 24'($urandom);
                    v.wt = 16'($urandom);
                    v.last = 1'($urandom_range(1));
                    v.typed = 0;
                    send_vertex(v);
                end
                v.idx = 5'(order[i]);
                v.row = 24'($urandom);
                if ($urandom_range(3) == 0) v.row = v.row & 24'($urandom);
                k = $urandom_range(3);
                v.wt = (k == 0) ? 16'($urandom_range(0, 3)) : (k == 1) ? 16'hFFFF
                                                                      : 16'($urandom);
                v.last = (i == order.size() - 1);
                v.typed = 0;
                send_vertex(v);
                items++;
            end
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;
        while (pending_cuts.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending_cuts.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
